// ===== src/segregated_bin_allocator_assert.svh =====
// Assertion macros for the segregated bin allocator checker.
// Included by the checker module only.
`ifndef SEGREGATED_BIN_ALLOCATOR_ASSERT_SVH
`define SEGREGATED_BIN_ALLOCATOR_ASSERT_SVH
`define SBA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/sba_pkg.sv =====
// Shared types and constants for the segregated bin allocator.
// No dependencies.
package sba_pkg;
    localparam int unsigned NUM_CLASSES = 32;
    localparam int unsigned PAGE_SHIFT = 12;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_ALIGN     = 3'd4;
    localparam logic [2:0] ST_TAG       = 3'd5;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [0:0] CFG_BASE  = 1'b0;
    localparam logic [0:0] CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic [31:0] head;
        logic [14:0] free_total;
        logic [14:0] live_total;
        logic [31:0] chunk_next;
        logic [8:0]  chunk_left;
    } class_rec_t;

    function automatic logic [31:0] class_bytes(input logic [4:0] c);
        logic [31:0] r;
        r = 32'd0;
        if (c < 5'd8)
            r = 32'd16 << c;
        else if (c < 5'd23)
            r = {15'd0, c - 5'd7, 12'd0};
        else
            r = 32'h10000 << (c - 5'd23);
        return r;
    endfunction

    function automatic logic [4:0] class_shift(input logic [4:0] c);
        return c + 5'd4;
    endfunction
endpackage

// ===== src/sba_class_mem.sv =====
// Per-class record memory: free list head, counts and chunk cursor.
// Depends on sba_pkg.
module sba_class_mem
(
    input  logic                clk,
    input  logic                rd_en,
    input  logic [4:0]          rd_addr,
    output sba_pkg::class_rec_t rd_data,
    input  logic                wr_en,
    input  logic [4:0]          wr_addr,
    input  sba_pkg::class_rec_t wr_data,
    input  logic                clr_en,
    input  logic [4:0]          clr_addr
);
    sba_pkg::class_rec_t mem [0:31];

    always_ff @(posedge clk)
    begin
        if (clr_en)
            mem[clr_addr] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

// ===== src/sba_link_mem.sv =====
// Free-block link memory, one word per 16-byte granule.
// No dependencies.
module sba_link_mem
#(
    parameter int unsigned DEPTH_LOG2 = 14
)
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [DEPTH_LOG2-1:0] rd_addr,
    output logic [31:0]           rd_data,
    input  logic                  wr_en,
    input  logic [DEPTH_LOG2-1:0] wr_addr,
    input  logic [31:0]           wr_data
);
    logic [31:0] mem [0:(1 << DEPTH_LOG2)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

// ===== src/sba_tag_mem.sv =====
// Page tag memory: in use, free count, class per heap page.
// No dependencies.
module sba_tag_mem
#(
    parameter int unsigned PAGES_LOG2 = 6
)
(
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [PAGES_LOG2-1:0] rd_addr,
    output logic [15:0]           rd_data,
    input  logic                  wr_en,
    input  logic [PAGES_LOG2-1:0] wr_addr,
    input  logic [15:0]           wr_data
);
    logic [15:0] mem [0:(1 << PAGES_LOG2)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

// ===== src/segregated_bin_allocator.sv =====
// Segregated bin allocator, top level: sequencer and configuration.
// Depends on sba_pkg, sba_class_mem, sba_link_mem, sba_tag_mem.
//
// One transaction at a time. start is taken at a clock edge where busy is low. The
// result shows for one cycle on done, in a cycle where busy is already low, so the
// next start can be taken at the edge that ends it. After reset a clearing pass over
// max(32, HEAP_PAGES) entries clears the class and page memories with busy high.
// An allocate from a free list or a chunk updates the tag of every page the block
// spans by read-modify-write through the single tag memory. Growing a chunk first
// writes the tag of every page of the new chunk. A free makes two passes over the
// pages of the block: one pass checks the tags, a second pass updates the counts.
// Null frees and errors found before the page walk end without a page walk.
// Results cannot be stalled.
module segregated_bin_allocator
#(
    parameter int unsigned HEAP_PAGES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [31:0] request_bytes,
    input  logic [31:0] block_address,
    output logic        done,
    output logic [31:0] result_address,
    output logic [2:0]  status
);
    localparam int unsigned PL = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
    localparam int unsigned LL = PL + 8;
    localparam int unsigned CW = (HEAP_PAGES > 32) ? PL + 1 : 6;
    localparam int unsigned CLR_LAST = (HEAP_PAGES > 32) ? HEAP_PAGES - 1 : 31;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_CLASS  = 11'b00000000100,
        S_REC    = 11'b00000001000,
        S_FTAG   = 11'b00000010000,
        S_FCHK   = 11'b00000100000,
        S_LINK   = 11'b00001000000,
        S_PREP   = 11'b00010000000,
        S_TRD    = 11'b00100000000,
        S_TWR    = 11'b01000000000,
        S_FIN    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [31:0] base_reg;
    logic [6:0]  limit_reg;
    logic [31:0] bump_reg, bump_next;
    logic        act_reg, act_next;
    logic [31:0] req_reg, req_next;
    logic [31:0] off_reg, off_next;
    logic [4:0]  cls_reg, cls_next;
    logic [2:0]  st_reg, st_next;
    sba_pkg::class_rec_t rec_reg, rec_next;
    logic [12:0] pg_reg, pg_next;
    logic [12:0] pend_reg, pend_next;
    logic [1:0]  tmode_reg, tmode_next;
    logic [8:0]  perpg_reg, perpg_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic [2:0]  stat_reg, stat_next;

    localparam logic [1:0] TM_GROW = 2'd0;
    localparam logic [1:0] TM_DEC  = 2'd1;
    localparam logic [1:0] TM_CHK  = 2'd2;
    localparam logic [1:0] TM_INC  = 2'd3;

    logic                cm_rd_en, cm_wr_en, cm_clr;
    logic [4:0]          cm_rd_addr;
    sba_pkg::class_rec_t cm_rd_data, cm_wr_data;
    logic                lm_rd_en, lm_wr_en;
    logic [LL-1:0]       lm_rd_addr, lm_wr_addr;
    logic [31:0]         lm_rd_data, lm_wr_data;
    logic                tm_rd_en, tm_wr_en;
    logic [PL-1:0]       tm_rd_addr, tm_wr_addr;
    logic [15:0]         tm_rd_data, tm_wr_data;

    sba_class_mem u_class (
        .clk(clk), .rd_en(cm_rd_en), .rd_addr(cm_rd_addr), .rd_data(cm_rd_data),
        .wr_en(cm_wr_en), .wr_addr(cls_reg), .wr_data(cm_wr_data),
        .clr_en(cm_clr), .clr_addr(clr_reg[4:0])
    );
    sba_link_mem #(.DEPTH_LOG2(LL)) u_link (
        .clk(clk), .rd_en(lm_rd_en), .rd_addr(lm_rd_addr), .rd_data(lm_rd_data),
        .wr_en(lm_wr_en), .wr_addr(lm_wr_addr), .wr_data(lm_wr_data)
    );
    sba_tag_mem #(.PAGES_LOG2(PL)) u_tag (
        .clk(clk), .rd_en(tm_rd_en), .rd_addr(tm_rd_addr), .rd_data(tm_rd_data),
        .wr_en(tm_wr_en), .wr_addr(tm_wr_addr), .wr_data(tm_wr_data)
    );

    // heap geometry
    logic [31:0] base_al;
    logic [20:0] room;
    logic [12:0] pages;
    logic [32:0] heap_end;
    always_comb
    begin
        base_al = {base_reg[31:12], 12'd0};
        room = 21'h100000 - {1'b0, base_al[31:12]};
        pages = ({6'd0, limit_reg} > 13'(HEAP_PAGES)) ? 13'(HEAP_PAGES)
                                                      : {6'd0, limit_reg};
        if ({8'd0, pages} > room)
            pages = room[12:0];
        heap_end = {8'd0, pages, 12'd0};
    end

    // class lookup
    logic [4:0] req_cls;
    logic       req_big;
    always_comb
    begin
        req_cls = 5'd0;
        req_big = 1'b1;
        for (int i = 31; i >= 0; i--)
            if (req_reg <= sba_pkg::class_bytes(5'(i)))
            begin
                req_cls = 5'(i);
                req_big = 1'b0;
            end
    end

    logic [31:0] sz;
    logic [12:0] span;
    logic        small_cls;
    assign sz = sba_pkg::class_bytes(cls_reg);
    assign small_cls = (cls_reg < 5'd8);
    assign span = small_cls ? 13'd1 : sz[24:12];

    logic [31:0] fofs;
    assign fofs = req_reg - base_al;

    logic [31:0] misal_mask;
    assign misal_mask = sz - 32'd1;

    logic [32:0] grow_end;
    assign grow_end = {1'b0, bump_reg} + (small_cls ? 33'h1000 : {1'b0, sz});

    logic [PL-1:0] pg_idx;
    assign pg_idx = pg_reg[PL-1:0];

    logic in_table;
    assign in_table = ({19'd0, pg_reg} < 32'(HEAP_PAGES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= 32'd1048576;
            limit_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sba_pkg::CFG_BASE:  base_reg  <= cfg_data;
                sba_pkg::CFG_LIMIT: limit_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        bump_next = bump_reg;
        act_next = act_reg;
        req_next = req_reg;
        off_next = off_reg;
        cls_next = cls_reg;
        st_next = st_reg;
        rec_next = rec_reg;
        pg_next = pg_reg;
        pend_next = pend_reg;
        tmode_next = tmode_reg;
        perpg_next = perpg_reg;
        done_next = 1'b0;
        res_next = res_reg;
        stat_next = stat_reg;
        cm_rd_en = 1'b0;
        cm_rd_addr = cls_reg;
        cm_wr_en = 1'b0;
        cm_wr_data = rec_reg;
        cm_clr = 1'b0;
        lm_rd_en = 1'b0;
        lm_rd_addr = rec_reg.head[LL+3:4];
        lm_wr_en = 1'b0;
        lm_wr_addr = off_reg[LL+3:4];
        lm_wr_data = rec_reg.head;
        tm_rd_en = 1'b0;
        tm_rd_addr = pg_idx;
        tm_wr_en = 1'b0;
        tm_wr_addr = pg_idx;
        tm_wr_data = tm_rd_data;

        unique case (state_reg)
            S_CLEAR:
            begin
                cm_clr = (clr_reg <= CW'(31));
                tm_wr_en = 1'b1;
                tm_wr_addr = clr_reg[PL-1:0];
                tm_wr_data = 16'd0;
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CLR_LAST))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    req_next = (action == sba_pkg::ACT_FREE) ? block_address : request_bytes;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                st_next = sba_pkg::ST_OK;
                if (act_reg == sba_pkg::ACT_ALLOC)
                begin
                    cls_next = req_cls;
                    cm_rd_en = 1'b1;
                    cm_rd_addr = req_cls;
                    if (req_big)
                    begin
                        st_next = sba_pkg::ST_TOO_LARGE;
                        state_next = S_FIN;
                    end
                    else
                        state_next = S_REC;
                end
                else
                begin
                    off_next = fofs;
                    pg_next = fofs[24:12];
                    if (req_reg == 32'd0)
                        state_next = S_FIN;
                    else if (req_reg < base_al || {1'b0, fofs} >= heap_end)
                    begin
                        st_next = sba_pkg::ST_RANGE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        tm_rd_en = 1'b1;
                        tm_rd_addr = fofs[PL+11:12];
                        state_next = S_FTAG;
                    end
                end
            end
            S_FTAG:
            begin
                cls_next = tm_rd_data[4:0];
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (sz <= 32'h1000 && (off_reg & misal_mask) != 32'd0)
                begin
                    st_next = sba_pkg::ST_ALIGN;
                    state_next = S_FIN;
                end
                else
                begin
                    cm_rd_en = 1'b1;
                    pend_next = span;
                    tmode_next = TM_CHK;
                    state_next = S_REC;
                end
            end
            S_REC:
            begin
                rec_next = cm_rd_data;
                if (act_reg == sba_pkg::ACT_FREE)
                    state_next = S_TRD;
                else if (cm_rd_data.free_total != 15'd0)
                begin
                    off_next = cm_rd_data.head;
                    lm_rd_en = 1'b1;
                    lm_rd_addr = cm_rd_data.head[LL+3:4];
                    state_next = S_LINK;
                end
                else
                    state_next = S_PREP;
            end
            S_LINK:
            begin
                rec_next.head = (off_reg[31:4] < 28'(1 << LL)) ? lm_rd_data : 32'd0;
                rec_next.free_total = rec_reg.free_total - 15'd1;
                rec_next.live_total = rec_reg.live_total + 15'd1;
                pg_next = off_reg[24:12];
                pend_next = (off_reg[31:25] != 7'd0) ? 13'd0 : span;
                tmode_next = TM_DEC;
                state_next = S_TRD;
            end
            S_PREP:
            begin
                if (rec_reg.chunk_left == 9'd0)
                begin
                    if (grow_end > heap_end)
                    begin
                        st_next = sba_pkg::ST_EXHAUSTED;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        perpg_next = small_cls ? 9'(32'h1000 >> sba_pkg::class_shift(cls_reg))
                                               : 9'd1;
                        rec_next.chunk_next = bump_reg;
                        rec_next.chunk_left = small_cls ? 9'(32'h1000 >>
                                              sba_pkg::class_shift(cls_reg)) : 9'd1;
                        pg_next = bump_reg[24:12];
                        pend_next = grow_end[24:12] - bump_reg[24:12];
                        bump_next = grow_end[31:0];
                        tmode_next = TM_GROW;
                        state_next = S_TWR;
                    end
                end
                else
                begin
                    off_next = rec_reg.chunk_next;
                    rec_next.chunk_left = rec_reg.chunk_left - 9'd1;
                    rec_next.chunk_next = rec_reg.chunk_next + sz;
                    rec_next.live_total = rec_reg.live_total + 15'd1;
                    pg_next = rec_reg.chunk_next[24:12];
                    pend_next = (rec_reg.chunk_next[31:25] != 7'd0) ? 13'd0 : span;
                    tmode_next = TM_DEC;
                    state_next = S_TRD;
                end
            end
            S_TRD:
            begin
                if (pend_reg == 13'd0 || (tmode_reg != TM_CHK && !in_table))
                begin
                    if (tmode_reg == TM_CHK)
                    begin
                        pg_next = off_reg[24:12];
                        pend_next = span;
                        tmode_next = TM_INC;
                    end
                    else
                        state_next = S_FIN;
                end
                else if (tmode_reg == TM_CHK && pg_reg >= pages)
                begin
                    st_next = sba_pkg::ST_TAG;
                    state_next = S_FIN;
                end
                else
                begin
                    tm_rd_en = 1'b1;
                    state_next = S_TWR;
                end
            end
            S_TWR:
            begin
                pg_next = pg_reg + 13'd1;
                pend_next = pend_reg - 13'd1;
                state_next = S_TRD;
                priority case (tmode_reg)
                    TM_GROW:
                    begin
                        tm_wr_en = in_table && pend_reg != 13'd0;
                        tm_wr_data = {1'b1, 1'b0, perpg_reg, cls_reg};
                        if (pend_reg == 13'd0 || !in_table)
                        begin
                            state_next = S_PREP;
                            pg_next = pg_reg;
                            pend_next = pend_reg;
                        end
                        else
                            state_next = S_TWR;
                    end
                    TM_DEC:
                    begin
                        tm_wr_en = 1'b1;
                        tm_wr_data = {tm_rd_data[15:14], tm_rd_data[13:5] - 9'd1,
                                      tm_rd_data[4:0]};
                    end
                    TM_INC:
                    begin
                        tm_wr_en = 1'b1;
                        tm_wr_data = {tm_rd_data[15:14], tm_rd_data[13:5] + 9'd1,
                                      tm_rd_data[4:0]};
                        if (pend_reg == 13'd1)
                        begin
                            rec_next.head = off_reg;
                            rec_next.live_total = rec_reg.live_total - 15'd1;
                            rec_next.free_total = rec_reg.free_total + 15'd1;
                            lm_wr_en = (off_reg[31:4] < 28'(1 << LL));
                        end
                    end
                    default:
                    begin
                        if (tm_rd_data[4:0] != cls_reg)
                        begin
                            st_next = sba_pkg::ST_TAG;
                            state_next = S_FIN;
                        end
                    end
                endcase
            end
            S_FIN:
            begin
                if (st_reg == sba_pkg::ST_OK && !(act_reg == sba_pkg::ACT_FREE &&
                    req_reg == 32'd0))
                    cm_wr_en = 1'b1;
                done_next = 1'b1;
                stat_next = st_reg;
                res_next = (st_reg == sba_pkg::ST_OK && act_reg == sba_pkg::ACT_ALLOC)
                           ? base_al + off_reg : 32'd0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            bump_reg <= 32'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            bump_reg <= bump_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        req_reg <= req_next;
        off_reg <= off_next;
        cls_reg <= cls_next;
        st_reg <= st_next;
        rec_reg <= rec_next;
        pg_reg <= pg_next;
        pend_reg <= pend_next;
        tmode_reg <= tmode_next;
        perpg_reg <= perpg_next;
        res_reg <= res_next;
        stat_reg <= stat_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result_address = res_reg;
    assign status = stat_reg;
endmodule

// ===== src/sba_checker.sv =====
// Port-level checker for the segregated bin allocator, with its bind.
// Depends on segregated_bin_allocator_assert.svh and sba_pkg.
`include "segregated_bin_allocator_assert.svh"
module sba_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] result_address,
    input logic [2:0]  status
);
    `SBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SBA_ASSERT_IMPL(a_done_busy, done, !$past(done))
    `SBA_ASSERT_IMPL(a_status_range, done, status <= sba_pkg::ST_TAG)
    `SBA_ASSERT_IMPL(a_err_zero, done && status != sba_pkg::ST_OK, result_address == 32'd0)
endmodule

bind segregated_bin_allocator sba_checker u_sba_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .result_address(result_address), .status(status)
);
